@@ rtl/positional_pid_controller_top_defines.svh @@
// Assertion macros for the positional PID controller checks.
`ifndef POSITIONAL_PID_CONTROLLER_TOP_DEFINES_SVH
`define POSITIONAL_PID_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PPID_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppid port check failed");

// next-cycle implication, sampled on clk, off during reset
`define PPID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppid port check failed");

`endif

@@ rtl/ppid_pkg.sv @@
// Types, constants and rounding helpers shared by the PID controller modules.
package ppid_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned GAIN_W    = 31;
	localparam int unsigned MODE_W    = 5;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned MUL_W     = 33;
	localparam int unsigned PROD_W    = 64;
	localparam int unsigned INC_W     = 48;
	localparam int unsigned SPLIT_W   = 16;
	localparam int unsigned CO_W      = 50;
	localparam int unsigned GAIN_FRAC = 16;
	localparam int unsigned RATE_FRAC = 15;
	localparam int unsigned RATE_ONE  = 32768;

	localparam int unsigned DEF_WINDUP_SHRINK_RATE = 16384;
	localparam int unsigned DEF_DEAD_DECAY_RATE    = 16384;
	localparam int unsigned DEF_DERIV_FILTER_RATE  = 16384;

	// feature_mode bit positions
	localparam int unsigned MODE_DZ_EN   = 0;
	localparam int unsigned MODE_ACT_LO  = 1;
	localparam int unsigned MODE_ACT_HI  = 2;
	localparam int unsigned MODE_FILT    = 3;
	localparam int unsigned MODE_FB_DERV = 4;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN,
		REG_INTEG_GAIN_DT,
		REG_DERIV_GAIN_PER_DT,
		REG_OUT_UPPER,
		REG_OUT_LOWER,
		REG_DEAD_LOW,
		REG_DEAD_HIGH,
		REG_FEATURE_MODE
	} reg_idx_t;

	typedef enum logic [1:0] {
		SAT_NONE,
		SAT_UPPER,
		SAT_LOWER
	} sat_code_t;

	typedef enum logic [1:0] {
		DZ_FULL,
		DZ_CLEAR,
		DZ_FREEZE,
		DZ_DECAY
	} dz_action_t;

	typedef struct packed {
		logic [DATA_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain_dt;
		logic [GAIN_W-1:0] deriv_gain_per_dt;
		logic [DATA_W-1:0] out_upper;
		logic [DATA_W-1:0] out_lower;
		logic [DATA_W-1:0] dead_low;
		logic [DATA_W-1:0] dead_high;
		logic [MODE_W-1:0] feature_mode;
	} ppid_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROP,
		ST_INTEG,
		ST_INC,
		ST_DEC_HI,
		ST_DEC_LO,
		ST_DEC_END,
		ST_ICLAMP,
		ST_FILT_A,
		ST_FILT_B,
		ST_FILT_C,
		ST_DERIV,
		ST_DSUM,
		ST_SAT,
		ST_SHRINK,
		ST_COMMIT
	} state_t;

	// round half up of x / 2^n
	function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] x,
			input int unsigned n);
		logic signed [PROD_W-1:0] half;
		half = signed'(PROD_W'(64'd1) << (n - 1));
		rnd_shr = (x + half) >>> n;
	endfunction

	// saturate a one-bit-wider signed value to the data width
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DATA_W:0] x);
		logic signed [DATA_W-1:0] res;
		if (x[DATA_W] != x[DATA_W-1]) begin
			res = x[DATA_W] ? signed'({1'b1, {(DATA_W-1){1'b0}}})
				: signed'({1'b0, {(DATA_W-1){1'b1}}});
		end else begin
			res = x[DATA_W-1:0];
		end
		sat_data = res;
	endfunction

endpackage

@@ rtl/ppid_cfg.sv @@
// Configuration register file of the PID controller.
module ppid_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ppid_pkg::IDX_W-1:0]      cfg_index,
	input  logic [ppid_pkg::DATA_W-1:0]     cfg_data,
	output ppid_pkg::ppid_cfg_t             cfg
);
	import ppid_pkg::*;

	ppid_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:         cfg_q.prop_gain         <= cfg_data;
				REG_INTEG_GAIN_DT:     cfg_q.integ_gain_dt     <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN_PER_DT: cfg_q.deriv_gain_per_dt <= cfg_data[GAIN_W-1:0];
				REG_OUT_UPPER:         cfg_q.out_upper         <= cfg_data;
				REG_OUT_LOWER:         cfg_q.out_lower         <= cfg_data;
				REG_DEAD_LOW:          cfg_q.dead_low          <= cfg_data;
				REG_DEAD_HIGH:         cfg_q.dead_high         <= cfg_data;
				REG_FEATURE_MODE:      cfg_q.feature_mode      <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/ppid_mul.sv @@
// Shared signed multiplier with a registered product.
module ppid_mul (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [ppid_pkg::MUL_W-1:0]      a,
	input  logic signed [ppid_pkg::MUL_W-1:0]      b,
	output logic signed [ppid_pkg::PROD_W-1:0]     prod
);
	import ppid_pkg::*;

	logic signed [2*MUL_W-1:0] full;
	logic signed [PROD_W-1:0]  prod_q;

	assign full = a * b;

	// hold the product until the next multiply
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= full[PROD_W-1:0];
		end
	end

	assign prod = prod_q;

endmodule

@@ rtl/positional_pid_controller_top.sv @@
// Positional PID controller with anti-windup, built around one shared multiplier.
//
//  channel | signals                          | transfer
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_ready, feedback,    | request taken on valid & ready
//          | target                           |
//  out     | out_valid, out_ready, drive,     | request taken on valid & ready
//          | sat_code                         |
//  cfg     | cfg_we, cfg_index, cfg_data      | write on cfg_we, no wait
//
// One request runs through the sequencer steps before the next is accepted; dead zone
// decay, the derivative filter and integral shrink each add steps when they apply.
// Every product goes through the single 33x33 multiplier, one after another.
// Reset clears the sequencer, the controller history and the output valid.
// A stalled output holds the sequencer in its last step; a new request is taken as soon
// as the result sits in the output register.
module positional_pid_controller_top #(
	parameter int unsigned WINDUP_SHRINK_RATE = ppid_pkg::DEF_WINDUP_SHRINK_RATE,
	parameter int unsigned DEAD_DECAY_RATE    = ppid_pkg::DEF_DEAD_DECAY_RATE,
	parameter int unsigned DERIV_FILTER_RATE  = ppid_pkg::DEF_DERIV_FILTER_RATE
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ppid_pkg::IDX_W-1:0]           cfg_index,
	input  logic [ppid_pkg::DATA_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [ppid_pkg::DATA_W-1:0]   feedback,
	input  logic signed [ppid_pkg::DATA_W-1:0]   target,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ppid_pkg::DATA_W-1:0]   drive,
	output logic [1:0]                           sat_code
);
	import ppid_pkg::*;

	localparam logic signed [MUL_W-1:0] SHRINK_OP    = MUL_W'(WINDUP_SHRINK_RATE);
	localparam logic signed [MUL_W-1:0] DECAY_OP     = MUL_W'(DEAD_DECAY_RATE);
	localparam logic signed [MUL_W-1:0] FILT_OP      = MUL_W'(DERIV_FILTER_RATE);
	localparam logic signed [MUL_W-1:0] FILT_REST_OP = MUL_W'(RATE_ONE - DERIV_FILTER_RATE);

	ppid_cfg_t cfg;
	state_t    state_q, state_d;

	logic                      mul_en;
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod;

	logic signed [DATA_W-1:0]  prop_gain, out_upper, out_lower, dead_low, dead_high;
	dz_action_t                dz_action;
	logic                      dz_on, filt_on, fb_deriv, integ_on, deriv_on, dz_hit;
	logic signed [DATA_W-1:0]  err_in, half, deriv_raw;
	logic signed [DATA_W:0]    half_sum, fb_diff, err_diff;
	logic signed [PROD_W-1:0]  p_rnd16, r15_sum, r15_prod;
	logic signed [INC_W:0]     isum, int_upper, int_lower;
	logic signed [DATA_W-1:0]  integ_new;
	logic signed [CO_W-1:0]    co_upper, co_lower;
	logic                      keep_d;
	sat_code_t                 code_d;
	logic signed [DATA_W-1:0]  drive_d;
	logic                      commit;

	logic signed [DATA_W-1:0]  fb_q, err_q, stored_q, integ_q, deriv_q, res_drive_q, drive_q;
	logic signed [INC_W-1:0]   inc_q;
	logic signed [PROD_W-1:0]  aux_q;
	logic signed [CO_W-1:0]    co_q;
	logic                      keep_q;
	sat_code_t                 res_code_q, sat_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  last_error_q, integral_acc_q, last_deriv_q, last_fb_q;
	logic                      first_q;

	ppid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppid_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign prop_gain = signed'(cfg.prop_gain);
	assign out_upper = signed'(cfg.out_upper);
	assign out_lower = signed'(cfg.out_lower);
	assign dead_low  = signed'(cfg.dead_low);
	assign dead_high = signed'(cfg.dead_high);
	assign dz_on     = cfg.feature_mode[MODE_DZ_EN];
	assign dz_action = dz_action_t'(cfg.feature_mode[MODE_ACT_HI:MODE_ACT_LO]);
	assign filt_on   = cfg.feature_mode[MODE_FILT];
	assign fb_deriv  = cfg.feature_mode[MODE_FB_DERV];
	assign integ_on  = (cfg.integ_gain_dt != '0);
	assign deriv_on  = (cfg.deriv_gain_per_dt != '0) && !first_q;
	assign dz_hit    = dz_on && (err_q >= dead_low) && (err_q <= dead_high);

	assign err_in = sat_data($signed({target[DATA_W-1], target})
		- $signed({feedback[DATA_W-1], feedback}));

	assign half_sum = $signed({last_error_q[DATA_W-1], last_error_q})
		+ $signed({err_q[DATA_W-1], err_q});
	assign half     = half_sum[DATA_W:1];

	assign fb_diff   = $signed({last_fb_q[DATA_W-1], last_fb_q}) - $signed({fb_q[DATA_W-1], fb_q});
	assign err_diff  = $signed({err_q[DATA_W-1], err_q})
		- $signed({last_error_q[DATA_W-1], last_error_q});
	assign deriv_raw = sat_data(fb_deriv ? fb_diff : err_diff);

	assign p_rnd16  = rnd_shr(prod, GAIN_FRAC);
	assign r15_sum  = rnd_shr(aux_q + prod, RATE_FRAC);
	assign r15_prod = rnd_shr(prod, RATE_FRAC);

	// integral clamp: upper limit tested first
	assign isum      = (INC_W+1)'(stored_q) + $signed({inc_q[INC_W-1], inc_q});
	assign int_upper = (INC_W+1)'(out_upper);
	assign int_lower = (INC_W+1)'(out_lower);

	always_comb begin
		if (!integ_on) begin
			integ_new = '0;
		end else if (isum > int_upper) begin
			integ_new = out_upper;
		end else if (isum < int_lower) begin
			integ_new = out_lower;
		end else begin
			integ_new = isum[DATA_W-1:0];
		end
	end

	assign co_upper = CO_W'(out_upper);
	assign co_lower = CO_W'(out_lower);

	// output clamp and anti-windup choice
	always_comb begin
		if (co_q >= co_upper) begin
			code_d  = SAT_UPPER;
			drive_d = out_upper;
			keep_d  = (err_q < 0);
		end else if (co_q <= co_lower) begin
			code_d  = SAT_LOWER;
			drive_d = out_lower;
			keep_d  = (err_q > 0);
		end else begin
			code_d  = SAT_NONE;
			drive_d = co_q[DATA_W-1:0];
			keep_d  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_en  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PROP;
				end
			end
			ST_PROP: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(err_q);
				mul_b   = MUL_W'(prop_gain);
				state_d = ST_INTEG;
			end
			ST_INTEG: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(half);
				mul_b   = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.integ_gain_dt});
				state_d = ST_INC;
			end
			ST_INC: begin
				state_d = (integ_on && dz_hit && dz_action == DZ_DECAY) ? ST_DEC_HI : ST_ICLAMP;
			end
			ST_DEC_HI: begin
				// increment split into a signed upper part and an unsigned lower part
				mul_en  = 1'b1;
				mul_a   = MUL_W'($signed(inc_q[INC_W-1:SPLIT_W]));
				mul_b   = DECAY_OP;
				state_d = ST_DEC_LO;
			end
			ST_DEC_LO: begin
				mul_en  = 1'b1;
				mul_a   = $signed({{(MUL_W-SPLIT_W){1'b0}}, inc_q[SPLIT_W-1:0]});
				mul_b   = DECAY_OP;
				state_d = ST_DEC_END;
			end
			ST_DEC_END: begin
				state_d = ST_ICLAMP;
			end
			ST_ICLAMP: begin
				state_d = (deriv_on && filt_on) ? ST_FILT_A : ST_DERIV;
			end
			ST_FILT_A: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(deriv_q);
				mul_b   = FILT_OP;
				state_d = ST_FILT_B;
			end
			ST_FILT_B: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(last_deriv_q);
				mul_b   = FILT_REST_OP;
				state_d = ST_FILT_C;
			end
			ST_FILT_C: begin
				state_d = ST_DERIV;
			end
			ST_DERIV: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(deriv_q);
				mul_b   = $signed({{(MUL_W-GAIN_W){1'b0}}, cfg.deriv_gain_per_dt});
				state_d = ST_DSUM;
			end
			ST_DSUM: begin
				state_d = ST_SAT;
			end
			ST_SAT: begin
				state_d = keep_d ? ST_COMMIT : ST_SHRINK;
			end
			ST_SHRINK: begin
				mul_en  = 1'b1;
				mul_a   = MUL_W'(stored_q);
				mul_b   = SHRINK_OP;
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					fb_q  <= feedback;
					err_q <= err_in;
				end
			end
			ST_PROP: begin
				stored_q <= (integ_on && dz_hit && dz_action == DZ_CLEAR) ? '0 : integral_acc_q;
				deriv_q  <= deriv_on ? deriv_raw : '0;
			end
			ST_INTEG: begin
				co_q <= CO_W'(p_rnd16);
			end
			ST_INC: begin
				inc_q <= (dz_hit && (dz_action == DZ_CLEAR || dz_action == DZ_FREEZE))
					? '0 : INC_W'(p_rnd16);
			end
			ST_DEC_LO: begin
				aux_q <= prod <<< SPLIT_W;
			end
			ST_DEC_END: begin
				inc_q <= INC_W'(r15_sum);
			end
			ST_ICLAMP: begin
				integ_q <= integ_new;
			end
			ST_FILT_B: begin
				aux_q <= prod;
			end
			ST_FILT_C: begin
				deriv_q <= DATA_W'(r15_sum);
			end
			ST_DERIV: begin
				co_q <= co_q + CO_W'(integ_q);
			end
			ST_DSUM: begin
				co_q <= co_q + CO_W'(p_rnd16);
			end
			ST_SAT: begin
				res_drive_q <= drive_d;
				res_code_q  <= code_d;
				keep_q      <= keep_d;
			end
			ST_COMMIT: begin
				if (commit) begin
					drive_q <= res_drive_q;
					sat_q   <= res_code_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			first_q        <= 1'b1;
			last_error_q   <= '0;
			integral_acc_q <= '0;
			last_deriv_q   <= '0;
			last_fb_q      <= '0;
		end else if (commit) begin
			out_valid_q    <= 1'b1;
			first_q        <= 1'b0;
			last_error_q   <= err_q;
			integral_acc_q <= keep_q ? integ_q : DATA_W'(r15_prod);
			last_deriv_q   <= deriv_q;
			last_fb_q      <= fb_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign sat_code  = sat_q;

endmodule

@@ rtl/ppid_chk.sv @@
// Port-level checks for the PID controller, bound to the top level.
`include "positional_pid_controller_top_defines.svh"

module ppid_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ppid_pkg::DATA_W-1:0]   drive,
	input logic [1:0]                    sat_code
);

	// one request at a time: busy right after a request is taken
	`PPID_ASSERT_NEXT(busy_after_accept, in_valid && in_ready, !in_ready)

	// a fresh result appears only as the sequencer returns to idle
	`PPID_ASSERT_SAME(result_frees_input, $rose(out_valid), in_ready)

	// a stalled result stays put
	`PPID_ASSERT_NEXT(result_held, out_valid && !out_ready,
		out_valid && $stable(drive) && $stable(sat_code))

endmodule

bind positional_pid_controller_top ppid_chk u_ppid_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive     (drive),
	.sat_code  (sat_code)
);

@@ verif/positional_pid_controller_top_tb.sv @@
// Self-checking testbench for the positional PID controller: directed corners, then random traffic.
module positional_pid_controller_top_tb;
	import ppid_pkg::*;

	localparam logic [31:0] Q_ONE   = 32'h0001_0000;
	localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN   = 32'h8000_0000;
	localparam longint SHRINK_RATE  = DEF_WINDUP_SHRINK_RATE;
	localparam longint DECAY_RATE   = DEF_DEAD_DECAY_RATE;
	localparam longint FILTER_RATE  = DEF_DERIV_FILTER_RATE;
	localparam longint UNITY_RATE   = RATE_ONE;

	typedef struct {
		logic signed [DATA_W-1:0] drive;
		sat_code_t                code;
	} pid_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [IDX_W-1:0]           cfg_index;
	logic [DATA_W-1:0]          cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [DATA_W-1:0]   feedback;
	logic signed [DATA_W-1:0]   target;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [DATA_W-1:0]   drive;
	logic [1:0]                 sat_code;

	positional_pid_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.feedback  (feedback),
		.target    (target),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.sat_code  (sat_code)
	);

	always #5 clk = ~clk;

	// controller settings as the block sees them
	longint     kp = 0, ki_dt = 0, kd_dt = 0, lim_hi = 0, lim_lo = 0, dz_lo = 0, dz_hi = 0;
	logic [4:0] mode = '0;

	// controller history
	longint     hist_err = 0, hist_integral = 0, hist_deriv = 0, hist_fb = 0;
	bit         hist_first = 1'b1;

	pid_result_t expected_drive_q[$];

	int          mismatch_count = 0;
	int          outputs_checked = 0;
	int          settings_count = 0;
	int          upper_count = 0, lower_count = 0, inside_count = 0;
	bit          idle_on = 1'b1;
	int unsigned rx_hold_cycles = 0;
	logic signed [DATA_W-1:0] walk_fb = '0, walk_sp = '0;

	function automatic longint clip32(input longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// round half up of x / 2^n
	function automatic longint round_q(input longint x, input int n);
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic pid_result_t predict_drive(input logic signed [DATA_W-1:0] fb_in,
			input logic signed [DATA_W-1:0] sp_in);
		longint      fb, err, keep, integ, inc, deriv, co;
		bit          in_zone;
		pid_result_t res;
		fb = fb_in;
		err = clip32(longint'(sp_in) - fb);
		keep = hist_integral;
		integ = 0;
		deriv = 0;
		if (ki_dt != 0) begin
			in_zone = mode[MODE_DZ_EN] && err >= dz_lo && err <= dz_hi;
			inc = round_q(((hist_err + err) >>> 1) * ki_dt, GAIN_FRAC);
			if (in_zone) begin
				case (dz_action_t'(mode[MODE_ACT_HI:MODE_ACT_LO]))
					DZ_CLEAR: begin
						inc = 0;
						keep = 0;
					end
					DZ_FREEZE: inc = 0;
					DZ_DECAY: inc = round_q(inc * DECAY_RATE, RATE_FRAC);
					default: ;
				endcase
			end
			integ = keep + inc;
			if (integ > lim_hi)
				integ = lim_hi;
			else if (integ < lim_lo)
				integ = lim_lo;
		end
		if (kd_dt != 0 && !hist_first) begin
			if (mode[MODE_FB_DERV])
				deriv = clip32(hist_fb - fb);
			else
				deriv = clip32(err - hist_err);
			if (mode[MODE_FILT])
				deriv = round_q(deriv * FILTER_RATE + hist_deriv * (UNITY_RATE - FILTER_RATE),
					RATE_FRAC);
		end
		co = round_q(kp * err, GAIN_FRAC) + integ + round_q(kd_dt * deriv, GAIN_FRAC);
		if (co >= lim_hi) begin
			keep = (err < 0) ? integ : round_q(keep * SHRINK_RATE, RATE_FRAC);
			res.drive = lim_hi[31:0];
			res.code = SAT_UPPER;
		end else if (co <= lim_lo) begin
			keep = (err > 0) ? integ : round_q(keep * SHRINK_RATE, RATE_FRAC);
			res.drive = lim_lo[31:0];
			res.code = SAT_LOWER;
		end else begin
			keep = integ;
			res.drive = co[31:0];
			res.code = SAT_NONE;
		end
		hist_integral = clip32(keep);
		hist_first = 1'b0;
		hist_err = err;
		hist_deriv = clip32(deriv);
		hist_fb = fb;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PROP_GAIN:         kp = longint'($signed(val));
			REG_INTEG_GAIN_DT:     ki_dt = longint'({1'b0, val[GAIN_W-1:0]});
			REG_DERIV_GAIN_PER_DT: kd_dt = longint'({1'b0, val[GAIN_W-1:0]});
			REG_OUT_UPPER:         lim_hi = longint'($signed(val));
			REG_OUT_LOWER:         lim_lo = longint'($signed(val));
			REG_DEAD_LOW:          dz_lo = longint'($signed(val));
			REG_DEAD_HIGH:         dz_hi = longint'($signed(val));
			REG_FEATURE_MODE:      mode = val[MODE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_results_drained();
		while (expected_drive_q.size() != 0)
			@(posedge clk);
	endtask

	// program all registers; only while nothing is in flight
	task automatic set_all(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
			input logic [31:0] hi, input logic [31:0] lo, input logic [31:0] zl,
			input logic [31:0] zh, input logic [31:0] m);
		stop_sending();
		wait_results_drained();
		write_reg(REG_PROP_GAIN, p);
		write_reg(REG_INTEG_GAIN_DT, i);
		write_reg(REG_DERIV_GAIN_PER_DT, d);
		write_reg(REG_OUT_UPPER, hi);
		write_reg(REG_OUT_LOWER, lo);
		write_reg(REG_DEAD_LOW, zl);
		write_reg(REG_DEAD_HIGH, zh);
		write_reg(REG_FEATURE_MODE, m);
		settings_count++;
	endtask

	task automatic send_sample(input logic signed [DATA_W-1:0] fb,
			input logic signed [DATA_W-1:0] sp);
		int unsigned gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		feedback <= fb;
		target <= sp;
		do
			@(posedge clk);
		while (!in_ready);
		expected_drive_q.push_back(predict_drive(fb, sp));
	endtask

	function automatic logic [31:0] rand_around(input int unsigned span);
		return 32'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [31:0] rand_gain();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return $urandom;
		if (pick == 1)
			return '0;
		return $urandom_range(0, 32'h0001_8000);
	endfunction

	task automatic program_random_setting();
		logic [31:0] p, hi, lo, zl, zh;
		int unsigned pick;
		pick = $urandom_range(0, 7);
		p = (pick == 0) ? $urandom : (pick == 1) ? '0 : rand_around(32'h0003_0000);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			// crossed limits
			hi = -($urandom_range(1, 32'h0040_0000));
			lo = $urandom_range(0, 32'h0040_0000);
		end else if (pick == 1) begin
			hi = $urandom;
			lo = $urandom;
		end else begin
			hi = $urandom_range(32'h0000_8000, 32'h07D0_0000);
			lo = -($urandom_range(32'h0000_8000, 32'h07D0_0000));
		end
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			zl = $urandom_range(1, 32'h0004_0000);
			zh = -($urandom_range(0, 32'h0004_0000));
		end else if (pick == 1) begin
			zl = $urandom;
			zh = $urandom;
		end else begin
			zl = -($urandom_range(0, 32'h0004_0000));
			zh = $urandom_range(0, 32'h0004_0000);
		end
		set_all(p, rand_gain(), rand_gain(), hi, lo, zl, zh, $urandom_range(0, 31));
	endtask

	// feedback mostly drifts toward the set point, with jumps and noise mixed in
	task automatic next_sample(output logic signed [DATA_W-1:0] fb,
			output logic signed [DATA_W-1:0] sp);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			walk_fb = $urandom;
			walk_sp = $urandom;
		end else if (pick < 11) begin
			walk_fb = ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
		end else if (pick < 17) begin
			walk_sp = rand_around(32'h0200_0000);
		end else if (pick < 75) begin
			walk_fb = walk_fb + ((walk_sp - walk_fb) >>> 3)
				+ $signed(rand_around(32'h0000_8000));
		end else begin
			walk_fb = walk_fb + rand_around(32'h0002_0000);
		end
		fb = walk_fb;
		sp = walk_sp;
	endtask

	task automatic run_traffic(input int count);
		logic signed [DATA_W-1:0] fb, sp;
		repeat (count) begin
			next_sample(fb, sp);
			send_sample(fb, sp);
		end
	endtask

	task automatic test_first_sample();
		// derivative on, filter on, feedback derivative: first step must give zero
		set_all('0, '0, Q_ONE, Q_MAX, Q_MIN, '0, '0, 32'h18);
		send_sample(32'sh0001_0000, '0);
		send_sample(32'sh0003_0000, '0);
	endtask

	task automatic test_error_limits();
		// dead zone on with integral disabled has no effect
		set_all(Q_ONE, '0, '0, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 32'h07);
		send_sample(Q_MIN, Q_MAX);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MAX, Q_MAX);
		send_sample(32'shFFFF_FFFF, 32'sh0000_0001);
	endtask

	task automatic test_derivative_paths();
		set_all('0, '0, Q_ONE, Q_MAX, Q_MIN, '0, '0, 32'h10);
		send_sample(Q_MIN, '0);
		// last feedback minus feedback overflows
		send_sample(Q_MAX, '0);
		set_all('0, '0, 32'h0000_8000, Q_MAX, Q_MIN, '0, '0, 32'h08);
		send_sample(Q_MAX, Q_MIN);
		send_sample(Q_MIN, Q_MAX);
	endtask

	task automatic test_dead_zone_actions();
		for (int act = DZ_FULL; act <= DZ_DECAY; act++) begin
			set_all('0, 32'h0000_8000, '0, 32'h0064_0000, 32'hFF9C_0000, 32'hFFFF_0000, Q_ONE,
				32'(1 + (act << MODE_ACT_LO)));
			send_sample(32'sh0005_0000, '0);
			send_sample(32'sh0000_8000, 32'sh0001_0000);
		end
		// empty zone with clear action: never inside
		set_all('0, 32'h0000_8000, '0, 32'h0064_0000, 32'hFF9C_0000, Q_ONE, 32'hFFFF_0000,
			32'(1 + (DZ_CLEAR << MODE_ACT_LO)));
		send_sample('0, 32'sh0000_4000);
	endtask

	task automatic test_clamp_and_windup();
		// output landing exactly on each limit
		set_all(Q_ONE, '0, '0, 32'h000A_0000, 32'hFFF6_0000, '0, '0, '0);
		send_sample('0, 32'sh000A_0000);
		send_sample(32'sh000A_0000, '0);
		// negative gain: clamped against the error sign keeps the new integral
		set_all(32'hFFFF_0000, Q_ONE, '0, 32'h000A_0000, 32'hFFF6_0000, '0, '0, '0);
		send_sample(32'sh0014_0000, '0);
		send_sample('0, 32'sh0014_0000);
		// crossed limits
		set_all('0, '0, '0, 32'hFFFB_0000, 32'h0005_0000, '0, '0, '0);
		send_sample('0, '0);
	endtask

	task automatic test_extreme_settings();
		set_all(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 32'h1F);
		run_traffic(100);
		// top bit of the integral and derivative gain registers is dropped
		set_all(Q_MIN, 32'hFFFF_FFFF, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, '0);
		run_traffic(100);
	endtask

	task automatic test_random_settings(input int phases);
		repeat (phases) begin
			program_random_setting();
			run_traffic(110);
		end
	endtask

	task automatic test_output_backpressure();
		program_random_setting();
		rx_hold_cycles = 150;
		run_traffic(60);
	endtask

	task automatic test_drain_pause();
		program_random_setting();
		run_traffic(40);
		stop_sending();
		wait_results_drained();
		run_traffic(40);
	endtask

	initial begin : ready_driver
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = 0;
			if (rx_hold_cycles != 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 9);
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_outputs
		pid_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_drive_q.size() == 0) begin
				report_mismatch($sformatf("unexpected output drive=%h sat_code=%0d", drive,
					sat_code));
			end else begin
				want = expected_drive_q.pop_front();
				if (drive !== want.drive)
					report_mismatch($sformatf("output %0d drive got %h want %h",
						outputs_checked, drive, want.drive));
				if (sat_code !== want.code)
					report_mismatch($sformatf("output %0d sat_code got %0d want %0d",
						outputs_checked, sat_code, want.code));
				case (want.code)
					SAT_UPPER: upper_count++;
					SAT_LOWER: lower_count++;
					default:   inside_count++;
				endcase
			end
			outputs_checked++;
		end
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PROP_GAIN;
		cfg_data = '0;
		in_valid = 1'b0;
		feedback = '0;
		target = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_sample();
		test_error_limits();
		test_derivative_paths();
		test_dead_zone_actions();
		test_clamp_and_windup();
		test_extreme_settings();
		test_random_settings(6);
		test_output_backpressure();
		test_drain_pause();
		// last stretch runs at full rate on both sides
		idle_on = 1'b0;
		test_random_settings(2);

		stop_sending();
		wait_results_drained();
		repeat (40) @(posedge clk);
		if (expected_drive_q.size() != 0)
			report_mismatch($sformatf("%0d outputs never arrived", expected_drive_q.size()));
		$display("Checked %0d controller outputs over %0d register settings.", outputs_checked,
			settings_count);
		$display("Clamped at upper %0d, at lower %0d, inside limits %0d.", upper_count,
			lower_count, inside_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ppid_pkg.sv
rtl/ppid_cfg.sv
rtl/ppid_mul.sv
rtl/positional_pid_controller_top.sv
rtl/ppid_chk.sv
verif/positional_pid_controller_top_tb.sv
